// File: hdl/slbs_pkg.sv
// shared types and constants for the status led blink sequencer
// no dependencies
package slbs_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_MS_W   = 16;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [2:0] {
        OP_SET_STATUS = 3'd0,
        OP_SHARE      = 3'd1,
        OP_BLOCK      = 3'd2,
        OP_TICK       = 3'd3,
        OP_TOGGLE_EN  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OFF        = 3'd0,
        ST_BOOT       = 3'd1,
        ST_AP         = 3'd2,
        ST_CONNECTING = 3'd3,
        ST_MINING     = 3'd4,
        ST_SHARE      = 3'd5,
        ST_BLOCK      = 3'd6,
        ST_ERROR      = 3'd7
    } t_status;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FLASH_HOLD   = 3'd0,
        REG_CELEBRATE    = 3'd1,
        REG_CELEB_BLINK  = 3'd2,
        REG_SLOW_ON      = 3'd3,
        REG_SLOW_OFF     = 3'd4,
        REG_FAST_ON      = 3'd5,
        REG_FAST_OFF     = 3'd6,
        REG_ACTIVE_LOW   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        new_status;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic       led_on;
        logic       pin_level;
        logic [2:0] status_now;
        logic       is_enabled;
    } t_out_item;

    typedef struct packed {
        logic [CFG_MS_W-1:0] flash_hold_ms;
        logic [CFG_MS_W-1:0] celebrate_ms;
        logic [CFG_MS_W-1:0] celebrate_blink_ms;
        logic [CFG_MS_W-1:0] slow_on_ms;
        logic [CFG_MS_W-1:0] slow_off_ms;
        logic [CFG_MS_W-1:0] fast_on_ms;
        logic [CFG_MS_W-1:0] fast_off_ms;
        logic                active_low;
    } t_cfg;

endpackage

// File: hdl/slbs_cfg_regs.sv
// apb configuration registers for the status led blink sequencer
// depends on slbs_pkg
module slbs_cfg_regs
    import slbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flash_hold_ms      <= CFG_MS_W'(500);
            r_cfg.celebrate_ms       <= CFG_MS_W'(3000);
            r_cfg.celebrate_blink_ms <= CFG_MS_W'(100);
            r_cfg.slow_on_ms         <= CFG_MS_W'(1000);
            r_cfg.slow_off_ms        <= CFG_MS_W'(1000);
            r_cfg.fast_on_ms         <= CFG_MS_W'(200);
            r_cfg.fast_off_ms        <= CFG_MS_W'(800);
            r_cfg.active_low         <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FLASH_HOLD:  r_cfg.flash_hold_ms      <= pwdata[CFG_MS_W-1:0];
                REG_CELEBRATE:   r_cfg.celebrate_ms       <= pwdata[CFG_MS_W-1:0];
                REG_CELEB_BLINK: r_cfg.celebrate_blink_ms <= pwdata[CFG_MS_W-1:0];
                REG_SLOW_ON:     r_cfg.slow_on_ms         <= pwdata[CFG_MS_W-1:0];
                REG_SLOW_OFF:    r_cfg.slow_off_ms        <= pwdata[CFG_MS_W-1:0];
                REG_FAST_ON:     r_cfg.fast_on_ms         <= pwdata[CFG_MS_W-1:0];
                REG_FAST_OFF:    r_cfg.fast_off_ms        <= pwdata[CFG_MS_W-1:0];
                REG_ACTIVE_LOW:  r_cfg.active_low         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FLASH_HOLD:  prdata = PDATA_W'(r_cfg.flash_hold_ms);
            REG_CELEBRATE:   prdata = PDATA_W'(r_cfg.celebrate_ms);
            REG_CELEB_BLINK: prdata = PDATA_W'(r_cfg.celebrate_blink_ms);
            REG_SLOW_ON:     prdata = PDATA_W'(r_cfg.slow_on_ms);
            REG_SLOW_OFF:    prdata = PDATA_W'(r_cfg.slow_off_ms);
            REG_FAST_ON:     prdata = PDATA_W'(r_cfg.fast_on_ms);
            REG_FAST_OFF:    prdata = PDATA_W'(r_cfg.fast_off_ms);
            REG_ACTIVE_LOW:  prdata = PDATA_W'(r_cfg.active_low);
            default:         prdata = '0;
        endcase
    end

endmodule

// File: hdl/slbs_engine.sv
// pattern state and next-state logic for the status led blink sequencer
// depends on slbs_pkg
module slbs_engine
    import slbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_status           r_cur, n_cur;
    t_status           r_saved, n_saved;
    logic              r_en, n_en;
    logic              r_lamp, n_lamp;
    logic [TIME_W-1:0] r_last_tog, n_last_tog;
    logic [TIME_W-1:0] r_flash_start, n_flash_start;

    logic [TIME_W-1:0] w_el_flash;
    logic [TIME_W-1:0] w_el_tog;

    assign w_el_flash = i_item.now_ms - r_flash_start;
    assign w_el_tog   = i_item.now_ms - r_last_tog;

    always_comb begin
        logic                go;
        logic                blink;
        logic [CFG_MS_W-1:0] on_t;
        logic [CFG_MS_W-1:0] off_t;
        t_status             st;

        n_cur         = r_cur;
        n_saved       = r_saved;
        n_en          = r_en;
        n_lamp        = r_lamp;
        n_last_tog    = r_last_tog;
        n_flash_start = r_flash_start;
        go            = 1'b0;
        blink         = 1'b0;
        on_t          = i_cfg.slow_on_ms;
        off_t         = i_cfg.slow_off_ms;
        st            = r_cur;

        case (t_op'(i_item.op))
            OP_SET_STATUS: begin
                if (i_item.new_status != r_cur) begin
                    n_saved = r_cur;
                    n_cur   = t_status'(i_item.new_status);
                end
            end
            OP_SHARE, OP_BLOCK: begin
                n_saved       = r_cur;
                n_cur         = (t_op'(i_item.op) == OP_SHARE) ? ST_SHARE : ST_BLOCK;
                n_flash_start = i_item.now_ms;
                n_lamp        = 1'b1;
            end
            OP_TICK: begin
                if (r_en) begin
                    go = 1'b1;
                    if (st == ST_SHARE) begin
                        if (w_el_flash >= TIME_W'(i_cfg.flash_hold_ms)) begin
                            st = r_saved;
                        end else begin
                            go = 1'b0;
                        end
                    end
                    if (go && st == ST_BLOCK) begin
                        if (w_el_flash >= TIME_W'(i_cfg.celebrate_ms)) begin
                            st = r_saved;
                        end else begin
                            go = 1'b0;
                            if (w_el_tog >= TIME_W'(i_cfg.celebrate_blink_ms)) begin
                                n_lamp     = !r_lamp;
                                n_last_tog = i_item.now_ms;
                            end
                        end
                    end
                    if (go) begin
                        case (st)
                            ST_OFF:              n_lamp = 1'b0;
                            ST_BOOT, ST_ERROR:   n_lamp = 1'b1;
                            ST_AP, ST_CONNECTING: begin
                                blink = 1'b1;
                                on_t  = i_cfg.slow_on_ms;
                                off_t = i_cfg.slow_off_ms;
                            end
                            ST_MINING: begin
                                blink = 1'b1;
                                on_t  = i_cfg.fast_on_ms;
                                off_t = i_cfg.fast_off_ms;
                            end
                            default: ;
                        endcase
                        if (blink) begin
                            if (r_lamp && w_el_tog >= TIME_W'(on_t)) begin
                                n_lamp     = 1'b0;
                                n_last_tog = i_item.now_ms;
                            end else if (!r_lamp && w_el_tog >= TIME_W'(off_t)) begin
                                n_lamp     = 1'b1;
                                n_last_tog = i_item.now_ms;
                            end
                        end
                    end
                    n_cur = st;
                end
            end
            OP_TOGGLE_EN: begin
                n_en = !r_en;
                if (r_en) begin
                    n_lamp = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_result.led_on     = n_lamp;
    assign o_result.pin_level  = n_lamp ^ i_cfg.active_low;
    assign o_result.status_now = n_cur;
    assign o_result.is_enabled = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur         <= ST_BOOT;
            r_saved       <= ST_OFF;
            r_en          <= 1'b1;
            r_lamp        <= 1'b0;
            r_last_tog    <= '0;
            r_flash_start <= '0;
        end else if (i_fire) begin
            r_cur         <= n_cur;
            r_saved       <= n_saved;
            r_en          <= n_en;
            r_lamp        <= n_lamp;
            r_last_tog    <= n_last_tog;
            r_flash_start <= n_flash_start;
        end
    end

endmodule

// File: hdl/status_led_blink_sequencer.sv
// Status LED blink sequencer: takes one request per clock while not stalled (op plus
// millisecond time stamp) and presents one result per request, in request order. A request
// is captured in an input register; when it moves on, it is applied to the pattern state
// and loads the result register, so throughput is one request per cycle whenever the output
// side is not stalled, bounded by the single state update per clock. Configuration is to be
// written by the user through the apb port while no request is in flight; the block does
// not enforce it. Depends on slbs_pkg, slbs_cfg_regs and slbs_engine.
module status_led_blink_sequencer
    import slbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_move;
    logic      w_accept;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    slbs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    slbs_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_move),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_move      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_move;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_data;
        end
        if (w_move) begin
            r_out_item <= w_result;
        end
    end

endmodule
